### hdl/sha256_byte_stream_hasher_macros.svh
// Assertion macros shared by the hasher modules.
// Depends on nothing; included by files that carry assertions.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

### hdl/sha_pkg.sv
// Package for the SHA-256 byte stream hasher: constants, tables, command types.
// Depends on nothing.
`timescale 1ns / 1ps
package sha_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned Rounds = 64;

  typedef logic [WordW-1:0] word_t;

  // Block sources for the datapath's load command.
  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_PAD,
    FILL_LEN
  } fill_op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     absorb;      // write a message byte
    logic     pad;         // write 0x80 and clear rest of block
    logic     len_only;    // clear words 0..13 before length
    logic     put_len;     // write length into words 14, 15
    logic     start;       // copy chaining words into working vars
    logic     round;       // run one round
    logic     fold;        // add working vars into chaining words
    logic     reinit;      // back to initial hash, clear counts
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } stat_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam word_t KTab [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction
endpackage

### hdl/sha_datapath.sv
// Datapath: block buffer, message schedule, round logic, chaining words.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_datapath
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [7:0] data_byte,
  input  logic [2:0] rd_index,
  output word_t      rd_word,
  output stat_t      stat
);
  `include "sha256_byte_stream_hasher_macros.svh"

  // The schedule window doubles as the block buffer.
  word_t      w [16];
  word_t      v [8];
  word_t      h [8];
  logic [5:0] fill;
  logic [5:0] rnd;
  logic [63:0] bit_len;

  word_t s0, s1, w_new, big0, big1, ch, maj, t1;

  // Round function and schedule extension.
  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    big1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + big1 + ch + KTab[rnd] + w[0];
    big0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  end

  // Block buffer and working variables.
  always_ff @(posedge clk) begin
    if (cmd.absorb || cmd.pad) begin
      for (int i = 0; i < 16; i++) begin
        if (i == int'(fill[5:2])) begin
          unique case (fill[1:0])
            2'd0: w[i][31:24] <= cmd.absorb ? data_byte : 8'h80;
            2'd1: w[i][23:16] <= cmd.absorb ? data_byte : 8'h80;
            2'd2: w[i][15:8]  <= cmd.absorb ? data_byte : 8'h80;
            default: w[i][7:0] <= cmd.absorb ? data_byte : 8'h80;
          endcase
          if (cmd.pad) begin
            unique case (fill[1:0])
              2'd0: w[i][23:0] <= '0;
              2'd1: w[i][15:0] <= '0;
              2'd2: w[i][7:0]  <= '0;
              default: ;
            endcase
          end
        end else if (cmd.pad && i > int'(fill[5:2])) begin
          w[i] <= '0;
        end
      end
    end else if (cmd.len_only) begin
      for (int i = 0; i < 14; i++) w[i] <= '0;
    end else if (cmd.put_len) begin
      w[14] <= bit_len[63:32];
      w[15] <= bit_len[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (cmd.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + big0 + maj;
    end
  end

  // Chaining words and counters.
  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
      fill    <= '0;
      bit_len <= '0;
      rnd     <= '0;
    end else begin
      if (cmd.absorb) begin
        fill    <= fill + 6'd1;
        bit_len <= bit_len + 64'd8;
      end
      if (cmd.start) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end
    end
  end

  assign rd_word         = h[rd_index];
  assign stat.fill       = fill;
  assign stat.last_round = (rnd == 6'(Rounds - 1));

  `SHA_ASSERT_IMP(a_one_cmd, clk, rst, cmd.round, !cmd.start && !cmd.absorb, "round overlaps load")
  `SHA_ASSERT_NEXT(a_rnd_wrap, clk, rst, cmd.round && stat.last_round, rnd == 6'd0, "round count")
  `SHA_ASSERT_IMP(a_no_pad_absorb, clk, rst, cmd.pad, !cmd.absorb, "pad with absorb")
endmodule

### hdl/sha_ctrl.sv
// Controller: sequences absorb, compression, padding and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       byte_valid,
  input  logic       last_in,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [2:0] out_index
);
  `include "sha256_byte_stream_hasher_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_RUN, ST_FOLD, ST_PAD, ST_LEN, ST_OUT
  } state_t;

  state_t     state;
  logic       closing;   // last seen, padding still pending
  logic       second;    // pad block overflowed, length block follows
  logic       final_blk; // running block ends with the digest
  logic       take;

  assign s_tready = (state == ST_IDLE);
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_OUT);

  always_comb begin
    cmd        = '0;
    cmd.absorb = take && byte_valid;
    cmd.round  = (state == ST_RUN);
    cmd.fold   = (state == ST_FOLD);
    cmd.pad    = (state == ST_PAD);
    cmd.len_only = (state == ST_LEN) && second;
    cmd.put_len  = (state == ST_LEN) && !second;
    cmd.start  = (state == ST_PAD && stat.fill >= 6'd56)
              || (state == ST_LEN && !second)
              || (take && byte_valid && stat.fill == 6'd63);
    cmd.reinit = (state == ST_OUT) && m_tready && out_index == 3'd7;
  end

  // State and registered flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      closing   <= 1'b0;
      second    <= 1'b0;
      final_blk <= 1'b0;
      out_index <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            closing <= last_in;
            if (byte_valid && stat.fill == 6'd63) begin
              state <= ST_RUN;
            end else if (last_in) begin
              state <= ST_PAD;
            end
          end
        end
        ST_RUN: if (stat.last_round) state <= ST_FOLD;
        ST_FOLD: begin
          if (final_blk) begin
            final_blk <= 1'b0;
            out_index <= '0;
            state     <= ST_OUT;
          end else if (second) begin
            state <= ST_LEN;
          end else if (closing) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PAD: begin
          closing <= 1'b0;
          if (stat.fill >= 6'd56) begin
            second <= 1'b1;
            state  <= ST_RUN;
          end else begin
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          if (second) begin
            second <= 1'b0;
          end else begin
            final_blk <= 1'b1;
            state     <= ST_RUN;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            out_index <= out_index + 3'd1;
            if (out_index == 3'd7) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_out_idle, clk, rst, m_tvalid, !s_tready, "output while taking input")
  `SHA_ASSERT_NEXT(a_run_hold, clk, rst, state == ST_RUN && !stat.last_round, state == ST_RUN, "left rounds early")
  `SHA_ASSERT_IMP(a_idx_zero, clk, rst, $rose(m_tvalid), out_index == 3'd0, "digest index start")
endmodule

### hdl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream; one byte per beat, 64 rounds per block.
// A byte that does not complete a block is taken while idle; a full block is compressed
// by one shared round unit, round by round, and then folded into the chaining words.
// Last adds a pad step and a length step (two when the pad spills into a second block)
// and a compression per closing block, then 8 digest beats.
// Synchronous active-high reset loads the initial hash and clears all counts.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // byte_valid
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] word_index, [34:3] digest_word, rest zero
  output logic        m_tlast    // last_word
);
  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] idx;
  word_t      word;

  sha_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready,
    .byte_valid(s_tuser), .last_in(s_tlast),
    .stat, .cmd, .m_tvalid, .m_tready, .out_index(idx)
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .data_byte(s_tdata),
    .rd_index(idx), .rd_word(word), .stat
  );

  // Result beat.
  assign m_tdata = {5'd0, word, idx};
  assign m_tlast = (idx == 3'd7);
endmodule

### verif/testbench.sv
// Testbench for the SHA-256 byte stream hasher: drives byte beats, predicts digests.
// Depends on sha_pkg and sha256_byte_stream_hasher.
`timescale 1ns / 1ps
module testbench;
  import sha_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  typedef struct {
    logic [2:0]  idx;
    logic [31:0] word;
    logic        fin;
  } digest_beat_t;

  digest_beat_t digest_queue[$];
  int           fail_count = 0;
  bit           hold_off = 1'b0;
  bit           idle_enable = 1'b1;

  // Predictor state.
  logic [31:0] hash_h[8];
  logic [31:0] blk[16];
  logic [5:0]  fill;
  logic [63:0] bit_len;

  sha256_byte_stream_hasher uut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] iv(input int i);
    logic [31:0] t[8];
    t = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return t[i];
  endfunction

  task automatic compress_into_hash();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic place_byte(input int pos, input logic [7:0] b);
    blk[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
  endtask

  // Advance the predictor by one accepted beat and queue any digest words.
  task automatic predict_digest(input logic [7:0] b, input logic bv, input logic lst);
    digest_beat_t d;
    if (bv) begin
      place_byte(fill, b);
      fill++;
      bit_len += 64'd8;
      if (fill == 6'd0) compress_into_hash();
    end
    if (lst) begin
      place_byte(fill, 8'h80);
      for (int p = fill + 1; p < 64; p++) place_byte(p, 8'h00);
      if (fill >= 6'd56) begin
        compress_into_hash();
        for (int i = 0; i < 14; i++) blk[i] = '0;
      end
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      compress_into_hash();
      for (int j = 0; j < 8; j++) begin
        d.idx = j[2:0];
        d.word = hash_h[j];
        d.fin = (j == 7);
        digest_queue.push_back(d);
      end
      for (int i = 0; i < 8; i++) hash_h[i] = iv(i);
      fill = '0;
      bit_len = '0;
    end
  endtask

  // Send one beat, with a random gap before it when idling is on.
  task automatic send_beat(input logic [7:0] b, input logic bv, input logic lst);
    int gap;
    gap = idle_enable ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= bv;
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    predict_digest(b, bv, lst);
  endtask

  task automatic end_stream();
    s_tvalid <= 1'b0;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom_range(255, 0)), 1'b1, i == len - 1);
    if (len == 0) send_beat(8'($urandom_range(255, 0)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    end_stream();
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls per beat, plus an optional long hold-off.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off) m_tready <= 1'b0;
      else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) stall = idle_enable ? $urandom_range(19, 0) : 0;
      end
    end
  end

  // Compare each accepted digest word with the oldest expectation.
  always @(posedge clk) begin
    digest_beat_t d;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest beat %h", m_tdata);
        fail_count++;
      end else begin
        d = digest_queue.pop_front();
        if (m_tdata[2:0] !== d.idx) begin
          $error("word_index expected %0d actual %0d", d.idx, m_tdata[2:0]);
          fail_count++;
        end
        if (m_tdata[34:3] !== d.word) begin
          $error("digest_word expected %h actual %h", d.word, m_tdata[34:3]);
          fail_count++;
        end
        if (m_tlast !== d.fin) begin
          $error("last_word expected %0d actual %0d", d.fin, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Empty message, idle beats, byte with last, and a message closed by an idle beat.
  task automatic test_directed();
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b0, 1'b0);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_boundaries();
    int lens[3] = '{55, 56, 64};
    foreach (lens[i]) send_message(lens[i]);
    wait_drained();
  endtask

  // Random messages: mostly short, with idle beats mixed in.
  task automatic test_random();
    int sent = 0;
    int len;
    while (sent < 90) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(70, 50) : $urandom_range(12, 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(7, 0) == 0) send_beat(8'($urandom_range(255, 0)), 1'b0, 1'b0);
        send_beat(8'($urandom_range(255, 0)), 1'b1, i == len - 1);
      end
      if (len == 0) send_beat(8'($urandom_range(255, 0)), 1'b0, 1'b1);
      sent += len + 1;
    end
    wait_drained();
  endtask

  // Receiver blocks for a long stretch while the sender offers beats with no gaps.
  task automatic test_backpressure();
    idle_enable = 1'b0;
    hold_off = 1'b1;
    fork
      begin
        repeat (800) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int m = 0; m < 4; m++) send_message($urandom_range(12, 1));
    join
    wait_drained();
    idle_enable = 1'b1;
  endtask

  initial begin
    fill = '0;
    bit_len = '0;
    for (int i = 0; i < 8; i++) hash_h[i] = iv(i);
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_boundaries();
    test_backpressure();
    test_random();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && digest_queue.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
